### design/blist_pkg.sv
// Shared types and codes for the bounded list with push, pop and insert.
// Holds the input and result word structs, operation and status codes.
// No dependencies.
package blist_pkg;

  // Default capacity of the list store
  localparam int unsigned DEPTH_DEF = 16;

  // Field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 5;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  // Input word
  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] word_in;
  } in_t;

  // Result word
  typedef struct packed {
    logic signed [DATA_W-1:0] word_out;
    logic [STAT_W-1:0]        status;
    logic [COUNT_W-1:0]       count_out;
  } out_t;

endpackage

### design/bounded_list_push_pop_insert_top.sv
// Bounded list of signed words with push, pop and insert at position.
// Depends on blist_pkg for word types, operation and status codes.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-------------------
//   in      | input     | in_valid_i / in_ready_o  | in_word_i   (in_t)
//   out     | output    | out_valid_o / out_ready_i| out_word_o  (out_t)
//
// Only one operation is taken at a time. Push, unused op and any rejected
// operation go straight to the result step; pop first reads the store.
// An insert works through the single memory port pair: each moved entry is
// one registered read followed by one write.
// Reset clears count and the handshake state; the store is not cleared.
// A result waiting on out_ready_i holds the sequencer in its last step.
module bounded_list_push_pop_insert_top #(
  parameter int unsigned DEPTH = blist_pkg::DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  blist_pkg::in_t  in_word_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output blist_pkg::out_t out_word_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > blist_pkg::POS_W) ? CW : blist_pkg::POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_WAIT,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_e;

  state_e                                state_q, state_d;
  logic [CW-1:0]                         count_q, count_d;
  logic [CW-1:0]                         idx_q, idx_d;
  logic [blist_pkg::POS_W-1:0]           pos_q, pos_d;
  logic signed [blist_pkg::DATA_W-1:0]   data_q, data_d;
  logic signed [blist_pkg::DATA_W-1:0]   res_word_q, res_word_d;
  logic [blist_pkg::STAT_W-1:0]          res_stat_q, res_stat_d;
  logic                                  out_valid_q, out_valid_d;
  blist_pkg::out_t                       out_q, out_d;

  // Memory port signals
  logic signed [blist_pkg::DATA_W-1:0]   mem_q [DEPTH];
  logic signed [blist_pkg::DATA_W-1:0]   rdata_q;
  logic                                  mem_we, mem_re;
  logic [AW-1:0]                         mem_waddr, mem_raddr;
  logic signed [blist_pkg::DATA_W-1:0]   mem_wdata;

  logic                                  in_acc;
  logic                                  full;
  logic [PW-1:0]                         pos_in_ext, pos_q_ext, count_ext, idx_ext;
  logic [CW-1:0]                         idx_dec, count_dec;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign full        = (count_q >= CW'(DEPTH));
  assign pos_in_ext  = PW'(in_word_i.position);
  assign pos_q_ext   = PW'(pos_q);
  assign count_ext   = PW'(count_q);
  assign idx_ext     = PW'(idx_q);
  assign idx_dec     = idx_q - CW'(1);
  assign count_dec   = count_q - CW'(1);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Sequence the operation and drive the memory port
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    data_d      = data_q;
    res_word_d  = res_word_q;
    res_stat_d  = res_stat_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = count_q[AW-1:0];
    mem_raddr   = count_dec[AW-1:0];
    mem_wdata   = data_q;

    // Drop the result once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          pos_d      = in_word_i.position;
          data_d     = in_word_i.word_in;
          res_word_d = '0;
          res_stat_d = blist_pkg::ST_OK;
          state_d    = S_DONE;
          case (in_word_i.op)
            blist_pkg::OP_PUSH: begin
              if (full) begin
                res_stat_d = blist_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_q[AW-1:0];
                mem_wdata = in_word_i.word_in;
                count_d   = count_q + CW'(1);
              end
            end
            blist_pkg::OP_POP: begin
              if (count_q == '0) begin
                res_stat_d = blist_pkg::ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = count_dec[AW-1:0];
                count_d   = count_dec;
                state_d   = S_POP_WAIT;
              end
            end
            blist_pkg::OP_INSERT: begin
              if (full) begin
                res_stat_d = blist_pkg::ST_FULL;
              end else if (pos_in_ext > count_ext) begin
                res_stat_d = blist_pkg::ST_RANGE;
              end else begin
                idx_d   = count_q;
                state_d = S_SHIFT_RD;
              end
            end
            default: begin
              res_stat_d = blist_pkg::ST_OK;
            end
          endcase
        end
      end
      S_POP_WAIT: begin
        res_word_d = rdata_q;
        state_d    = S_DONE;
      end
      S_SHIFT_RD: begin
        if (idx_ext > pos_q_ext) begin
          // Fetch the entry below the hole
          mem_re    = 1'b1;
          mem_raddr = idx_dec[AW-1:0];
          state_d   = S_SHIFT_WR;
        end else begin
          // Drop the new word into the hole
          mem_we    = 1'b1;
          mem_waddr = AW'(pos_q);
          mem_wdata = data_q;
          count_d   = count_q + CW'(1);
          state_d   = S_DONE;
        end
      end
      S_SHIFT_WR: begin
        // Move the fetched entry up by one place
        mem_we    = 1'b1;
        mem_waddr = idx_q[AW-1:0];
        mem_wdata = rdata_q;
        idx_d     = idx_dec;
        state_d   = S_SHIFT_RD;
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_d.word_out  = res_word_q;
          out_d.status    = res_stat_q;
          out_d.count_out = blist_pkg::COUNT_W'(count_q);
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state, count and the result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    pos_q      <= pos_d;
    data_q     <= data_d;
    res_word_q <= res_word_d;
    res_stat_q <= res_stat_d;
    out_q      <= out_d;
  end

  // List store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // Count never exceeds capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("list count above capacity");

  // An accepted push on a non-full list grows the count by one
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_word_i.op == blist_pkg::OP_PUSH && !full)
    |=> count_q == $past(count_q) + CW'(1))
    else $error("push did not grow count");

  // A shift write always moves an entry above the insert position
  a_shift_above_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT_WR) |-> (idx_ext > pos_q_ext && idx_q <= count_q))
    else $error("shift index out of range");

  // An empty pop returns a zero word
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == blist_pkg::ST_EMPTY) |-> out_q.word_out == '0)
    else $error("empty pop returned nonzero word");

endmodule

### dv/bounded_list_push_pop_insert_top_tb.sv
// Self-checking testbench for bounded_list_push_pop_insert_top: push, pop and
// insert words are driven over valid/ready and every result word is scored.
// Depends on blist_pkg and the top level of the list block.
module bounded_list_push_pop_insert_top_tb;

  localparam int unsigned LIST_DEPTH = blist_pkg::DEPTH_DEF;
  localparam logic [blist_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RAND_PER_MIX = 500;
  localparam int LONG_HOLD = 300;

  // Track list contents and score result words in order
  class list_scoreboard;
    logic [blist_pkg::DATA_W-1:0] store [LIST_DEPTH];
    int unsigned                  count;
    blist_pkg::out_t              pending_results [$];
    int                           errors;
    int                           mismatches;
    int                           checked;
    int                           full_hits;
    int                           empty_hits;
    int                           range_hits;

    function new();
      count      = 0;
      errors     = 0;
      mismatches = 0;
      checked    = 0;
      full_hits  = 0;
      empty_hits = 0;
      range_hits = 0;
    endfunction

    // Apply one operation to the shadow list and return its result word
    function blist_pkg::out_t apply_op(blist_pkg::in_t w);
      blist_pkg::out_t r;
      int unsigned     i;
      r.word_out = '0;
      r.status   = blist_pkg::ST_OK;
      case (w.op)
        blist_pkg::OP_PUSH: begin
          if (count >= LIST_DEPTH) begin
            r.status = blist_pkg::ST_FULL;
          end else begin
            store[count] = w.word_in;
            count++;
          end
        end
        blist_pkg::OP_POP: begin
          if (count == 0) begin
            r.status = blist_pkg::ST_EMPTY;
          end else begin
            count--;
            r.word_out = store[count];
          end
        end
        blist_pkg::OP_INSERT: begin
          if (count >= LIST_DEPTH) begin
            r.status = blist_pkg::ST_FULL;
          end else if (w.position > count) begin
            r.status = blist_pkg::ST_RANGE;
          end else begin
            for (i = count; i > w.position; i--) begin
              store[i] = store[i-1];
            end
            store[w.position] = w.word_in;
            count++;
          end
        end
        default: ;
      endcase
      r.count_out = blist_pkg::COUNT_W'(count);
      return r;
    endfunction

    // Note an accepted input word
    function void note_word(blist_pkg::in_t w);
      blist_pkg::out_t r;
      r = apply_op(w);
      if (r.status == blist_pkg::ST_FULL) full_hits++;
      if (r.status == blist_pkg::ST_EMPTY) empty_hits++;
      if (r.status == blist_pkg::ST_RANGE) range_hits++;
      pending_results.push_back(r);
    endfunction

    // Compare an accepted result word with the oldest prediction
    function void check_word(blist_pkg::out_t got);
      blist_pkg::out_t want;
      if (pending_results.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result word: word %0d status %0d count %0d",
                   got.word_out, got.status, got.count_out);
        end
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.word_out !== want.word_out || got.status !== want.status ||
          got.count_out !== want.count_out) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: want word %0d status %0d count %0d,",
                   want.word_out, want.status, want.count_out,
                   " got word %0d status %0d count %0d",
                   got.word_out, got.status, got.count_out);
        end
      end
    endfunction

    // Flag predictions that never got a result
    function void close_out();
      if (pending_results.size() != 0) begin
        errors++;
        $display("%0d result words never arrived", pending_results.size());
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  blist_pkg::in_t  in_word_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  blist_pkg::out_t out_word_o;

  list_scoreboard sb = new();
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;
  int    hold_req = 0;
  int    list_len_guess = 0;
  int    words_sent = 0;

  bounded_list_push_pop_insert_top #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sample both handshakes and feed the scoreboard
  always @(posedge clk) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_word(in_word_i);
      if (out_valid_o && out_ready_i) sb.check_word(out_word_o);
    end
  end

  // Drive out_ready_i: random idling, or a long hold when requested
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic blist_pkg::in_t make_word(logic [blist_pkg::OP_W-1:0] op,
                                               logic [blist_pkg::POS_W-1:0] pos,
                                               logic [blist_pkg::DATA_W-1:0] data);
    blist_pkg::in_t w;
    w.op       = op;
    w.position = pos;
    w.word_in  = data;
    return w;
  endfunction

  // Pick a data value, now and then one of the extremes
  function automatic logic [blist_pkg::DATA_W-1:0] pick_data();
    case ($urandom_range(15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Build a random operation; grow biases toward filling the list
  function automatic blist_pkg::in_t random_word(int cnt, bit grow);
    int                          roll;
    logic [blist_pkg::OP_W-1:0]  op;
    logic [blist_pkg::POS_W-1:0] pos;
    roll = $urandom_range(99);
    pos  = blist_pkg::POS_W'($urandom);
    if (roll < 3) begin
      op = OP_UNUSED;
    end else if (roll < (grow ? 43 : 15)) begin
      op = blist_pkg::OP_PUSH;
    end else if (roll < (grow ? 63 : 80)) begin
      op = blist_pkg::OP_POP;
    end else begin
      op = blist_pkg::OP_INSERT;
      if ($urandom_range(9) != 0) pos = blist_pkg::POS_W'($urandom_range(cnt, 0));
    end
    return make_word(op, pos, pick_data());
  endfunction

  // Offer one word, with a random gap first, and hold it until accepted
  task automatic send_word(blist_pkg::in_t w);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk); while (!in_ready_o);
    words_sent++;
    // Advance the length guess used to aim insert positions
    case (w.op)
      blist_pkg::OP_PUSH:   if (list_len_guess < LIST_DEPTH) list_len_guess++;
      blist_pkg::OP_POP:    if (list_len_guess > 0) list_len_guess--;
      blist_pkg::OP_INSERT: if (list_len_guess < LIST_DEPTH &&
                                w.position <= list_len_guess)
                              list_len_guess++;
      default: ;
    endcase
  endtask

  // Main sequence: reset, directed words, three random idle mixes, drain
  initial begin
    int  mix;
    int  k;
    int  drain;
    bit  grow;
    grow = 1'b1;
    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // Directed: empty pop, range checks, extremes, fill to full and reject
    send_word(make_word(blist_pkg::OP_POP, 5'd0, 32'h0));
    send_word(make_word(blist_pkg::OP_INSERT, 5'd1, 32'h1234_5678));
    send_word(make_word(blist_pkg::OP_INSERT, 5'd0, 32'h7FFF_FFFF));
    send_word(make_word(blist_pkg::OP_PUSH, 5'd31, 32'h8000_0000));
    send_word(make_word(blist_pkg::OP_INSERT, 5'd31, 32'h5555_AAAA));
    send_word(make_word(blist_pkg::OP_INSERT, 5'd2, 32'h0));
    send_word(make_word(blist_pkg::OP_INSERT, 5'd1, 32'hFFFF_FFFF));
    send_word(make_word(OP_UNUSED, 5'd31, 32'hFFFF_FFFF));
    send_word(make_word(blist_pkg::OP_INSERT, 5'd0, $urandom));
    send_word(make_word(blist_pkg::OP_POP, 5'd31, 32'hFFFF_FFFF));
    for (k = 0; k < 12; k++) begin
      send_word(make_word(blist_pkg::OP_PUSH, blist_pkg::POS_W'($urandom), $urandom));
    end
    send_word(make_word(blist_pkg::OP_PUSH, 5'd0, 32'hDEAD_BEEF));
    send_word(make_word(blist_pkg::OP_INSERT, 5'd31, 32'hCAFE_F00D));
    send_word(make_word(blist_pkg::OP_POP, 5'd0, 32'h0));

    // Random: sender 29 / receiver 69, then swapped, then no idling with a long output hold
    for (mix = 0; mix < 3; mix++) begin
      send_idle_pct = (mix == 0) ? 29 : (mix == 1) ? 69 : 0;
      recv_idle_pct = (mix == 0) ? 69 : (mix == 1) ? 29 : 0;
      if (mix == 2) hold_req = LONG_HOLD;
      for (k = 0; k < RAND_PER_MIX; k++) begin
        if ($urandom_range(39) == 0) grow = ~grow;
        send_word(random_word(list_len_guess, grow));
      end
    end
    in_valid_i <= 1'b0;

    // Drain outstanding results, then let the block settle
    drain = 0;
    while (sb.pending_results.size() > 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (60) @(posedge clk);
    sb.close_out();

    $display("Ran %0d words through three idle mixes plus a %0d-cycle output hold",
             words_sent, LONG_HOLD);
    $display("Checked %0d results: %0d full, %0d empty, %0d out-of-range rejections",
             sb.checked, sb.full_hits, sb.empty_hits, sb.range_hits);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### sim.f
design/blist_pkg.sv
design/bounded_list_push_pop_insert_top.sv
dv/bounded_list_push_pop_insert_top_tb.sv
